// File: design/sbmf_pkg.sv
// Package for the separable box mean filter.
// Holds frame limits, datapath widths, register indexes and the reciprocal table.
// No dependencies.
package sbmf_pkg;

   // frame limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int MAX_RADIUS = 15;
   localparam int RING_ROWS  = 2 * MAX_RADIUS + 2;

   // widths
   localparam int PIX_W   = 8;
   localparam int WORD_W  = 4 * PIX_W;
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int RING_W  = $clog2(RING_ROWS);
   localparam int ADDR_W  = RING_W + COL_W;
   localparam int DEPTH   = RING_ROWS * MAX_WIDTH;
   localparam int CNT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int RAD_W   = 4;
   localparam int WIN_W   = $clog2(2 * MAX_RADIUS + 1);
   localparam int SUM_W   = $clog2((2 * MAX_RADIUS + 1) * 255 + MAX_RADIUS + 1);
   localparam int LAT_W   = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
   localparam int WID_W   = 11;
   localparam int HGT_W   = 13;
   localparam int CHN_W   = 3;
   localparam int NLANES  = 3;

   // reciprocal divide: q = (x * ceil(2^SHIFT / k)) >> SHIFT, exact for x*k < 2^SHIFT
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = 23;
   localparam int PROD_W      = SUM_W + RECIP_W;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] REG_RADIUS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL = 2'd3;

   localparam logic [RAD_W-1:0] RADIUS_RST  = 4'd1;
   localparam logic [WID_W-1:0] WIDTH_RST   = 11'd640;
   localparam logic [HGT_W-1:0] HEIGHT_RST  = 13'd480;
   localparam logic [CHN_W-1:0] CHANNEL_RST = 3'd3;

   localparam logic [CHN_W-1:0] CHAN_ALPHA = 3'd4;

   localparam logic ACT_PIXEL = 1'b0;
   localparam logic ACT_FLUSH = 1'b1;

   // ceil(2^24 / (2r+1)) for r = 1..15
   function automatic logic [RECIP_W-1:0] recip_of(input logic [RAD_W-1:0] r);
      case (r)
         4'd1:    return 23'd5592406;
         4'd2:    return 23'd3355444;
         4'd3:    return 23'd2396746;
         4'd4:    return 23'd1864136;
         4'd5:    return 23'd1525202;
         4'd6:    return 23'd1290556;
         4'd7:    return 23'd1118482;
         4'd8:    return 23'd986896;
         4'd9:    return 23'd883012;
         4'd10:   return 23'd798916;
         4'd11:   return 23'd729445;
         4'd12:   return 23'd671089;
         4'd13:   return 23'd621379;
         4'd14:   return 23'd578525;
         4'd15:   return 23'd541201;
         default: return '0;
      endcase
   endfunction

endpackage

// File: design/sbmf_req_if.sv
// Request channel of the box mean filter: one pixel or flush step per transaction.
// Depends on sbmf_pkg.
interface sbmf_req_if;
   logic                        valid;
   logic                        ready;
   logic                        action;
   logic [sbmf_pkg::PIX_W-1:0]  in_chan0;
   logic [sbmf_pkg::PIX_W-1:0]  in_chan1;
   logic [sbmf_pkg::PIX_W-1:0]  in_chan2;
   logic [sbmf_pkg::PIX_W-1:0]  in_alpha;

   modport source (output valid, action, in_chan0, in_chan1, in_chan2, in_alpha,
                   input ready);
   modport sink   (input valid, action, in_chan0, in_chan1, in_chan2, in_alpha,
                   output ready);
endinterface

// File: design/sbmf_rsp_if.sv
// Response channel of the box mean filter: one filtered pixel per transaction.
// Depends on sbmf_pkg.
interface sbmf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sbmf_pkg::PIX_W-1:0]  out_chan0;
   logic [sbmf_pkg::PIX_W-1:0]  out_chan1;
   logic [sbmf_pkg::PIX_W-1:0]  out_chan2;
   logic [sbmf_pkg::PIX_W-1:0]  out_alpha;
   logic                        frame_last;

   modport source (output valid, out_chan0, out_chan1, out_chan2, out_alpha, frame_last,
                   input ready);
   modport sink   (input valid, out_chan0, out_chan1, out_chan2, out_alpha, frame_last,
                   output ready);
endinterface

// File: design/separable_box_mean_filter.sv
// Separable box mean filter, top level. Depends on sbmf_pkg, sbmf_req_if, sbmf_rsp_if.
// Single module: pixel ring memory, window sequencer and output register.
//
// Raster pixels come in on req_port, filtered pixels leave on rsp_port in raster
// order, radius rows plus radius pixels behind the input; flush transactions drain
// the tail once the whole frame is in. Every incoming pixel is written to a ring
// memory of 32 rows x 1024 columns (one 32-bit word per pixel). A pixel or flush
// transaction that yields no result leaves the sequencer in idle. For one that
// yields a result the window is read one pixel per cycle through the
// single read port of the ring memory, each row sum is divided as it completes,
// then the column of row means is divided. A finished result waits in the output
// register, so the next transaction is taken while rsp is stalled. A CSR write
// taken while idle restarts the frame; one in any other state is ignored. req is
// held off in the cycle of a CSR write. No clearing pass is needed after reset.
module separable_box_mean_filter (
   input  logic                                clock,
   input  logic                                reset,
   sbmf_req_if.sink                            req_port,
   sbmf_rsp_if.source                          rsp_port,
   input  logic                                csr_wr_en,
   input  logic [sbmf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sbmf_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,   // waiting for a transaction
      ST_ALPHA,  // read center pixel (alpha)
      ST_ROW,    // issue one window read per cycle
      ST_HWAIT,  // last read of the row lands
      ST_HDIV,   // row sum times reciprocal
      ST_HACC,   // add row mean into column sum
      ST_VDIV,   // column sum times reciprocal
      ST_FIN     // hand result to output register
   } state_type;

   localparam int CW = sbmf_pkg::COL_W;
   localparam int RW = sbmf_pkg::ROW_W;
   localparam int NW = sbmf_pkg::CNT_W;
   localparam int SW = sbmf_pkg::SUM_W;
   localparam int PW = sbmf_pkg::PIX_W;

   // ---------------- registers ----------------
   state_type                       state_ff, state_in;
   logic [sbmf_pkg::RAD_W-1:0]      radius_ff, radius_in;
   logic [sbmf_pkg::WID_W-1:0]      width_ff, width_in;
   logic [sbmf_pkg::HGT_W-1:0]      height_ff, height_in;
   logic [sbmf_pkg::CHN_W-1:0]      chan_ff, chan_in;

   logic [NW-1:0]  in_cnt_ff, in_cnt_in, out_cnt_ff, out_cnt_in;
   logic [CW-1:0]  in_x_ff, in_x_in, out_x_ff, out_x_in;
   logic [RW-1:0]  in_y_ff, in_y_in, out_y_ff, out_y_in;

   // window walk
   logic [CW-1:0]  wx_ff, wx_in;
   logic [RW-1:0]  wy_ff, wy_in;
   logic [sbmf_pkg::WIN_W-1:0] i_ff, i_in, j_ff, j_in;
   logic           wlast_ff, wlast_in;
   logic           rd_vld_ff, rd_vld_in;
   logic           alpha_pend_ff, alpha_pend_in;
   logic [PW-1:0]  alpha_ff, alpha_in;

   logic [SW-1:0]                 hs_ff [sbmf_pkg::NLANES];
   logic [SW-1:0]                 hs_in [sbmf_pkg::NLANES];
   logic [SW-1:0]                 vs_ff [sbmf_pkg::NLANES];
   logic [SW-1:0]                 vs_in [sbmf_pkg::NLANES];
   logic [sbmf_pkg::PROD_W-1:0]   prod_ff [sbmf_pkg::NLANES];
   logic [sbmf_pkg::PROD_W-1:0]   prod_in [sbmf_pkg::NLANES];
   logic [SW-1:0]                 mul_a [sbmf_pkg::NLANES];

   // output register
   logic           rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]  rsp_c_ff [sbmf_pkg::NLANES];
   logic [PW-1:0]  rsp_c_in [sbmf_pkg::NLANES];
   logic [PW-1:0]  rsp_alpha_ff, rsp_alpha_in;
   logic           rsp_last_ff, rsp_last_in;

   // ring memory
   logic [sbmf_pkg::WORD_W-1:0]   pix_mem [sbmf_pkg::DEPTH];
   logic [sbmf_pkg::WORD_W-1:0]   rd_data_ff;
   logic [sbmf_pkg::ADDR_W-1:0]   rd_addr, wr_addr;
   logic [sbmf_pkg::WORD_W-1:0]   wr_data;
   logic                          mem_we;

   // ---------------- effective configuration ----------------
   logic [sbmf_pkg::WID_W-1:0]    w_eff, wm1;
   logic [sbmf_pkg::HGT_W-1:0]    h_eff, hm1, lim_wh;
   logic [sbmf_pkg::CHN_W-1:0]    ch_eff;
   logic [sbmf_pkg::RAD_W-1:0]    lim, r_eff;
   logic [sbmf_pkg::RECIP_W-1:0]  recip;
   logic [NW:0]                   total_full;
   logic [NW-1:0]                 total;
   logic [sbmf_pkg::LAT_W-1:0]    lat;

   always_comb begin
      if (width_ff < 11'd2) begin
         w_eff = 11'd2;
      end else if (width_ff > sbmf_pkg::WID_W'(sbmf_pkg::MAX_WIDTH)) begin
         w_eff = sbmf_pkg::WID_W'(sbmf_pkg::MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff < 13'd2) begin
         h_eff = 13'd2;
      end else if (height_ff > sbmf_pkg::HGT_W'(sbmf_pkg::MAX_HEIGHT)) begin
         h_eff = sbmf_pkg::HGT_W'(sbmf_pkg::MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      if (chan_ff == 3'd0) begin
         ch_eff = 3'd1;
      end else if (chan_ff > sbmf_pkg::CHAN_ALPHA) begin
         ch_eff = sbmf_pkg::CHAN_ALPHA;
      end else begin
         ch_eff = chan_ff;
      end
      wm1 = w_eff - 11'd1;
      hm1 = h_eff - 13'd1;
      lim_wh = ({2'b00, wm1} < hm1) ? {2'b00, wm1} : hm1;
      lim = (lim_wh > 13'(sbmf_pkg::MAX_RADIUS)) ? sbmf_pkg::RAD_W'(sbmf_pkg::MAX_RADIUS)
                                                 : lim_wh[sbmf_pkg::RAD_W-1:0];
      if (radius_ff == 4'd0) begin
         r_eff = 4'd1;
      end else if (radius_ff > lim) begin
         r_eff = lim;
      end else begin
         r_eff = radius_ff;
      end
      recip = sbmf_pkg::recip_of(r_eff);
      total_full = (NW+1)'({13'd0, w_eff} * {11'd0, h_eff});
      total = total_full[NW-1:0];
      lat = sbmf_pkg::LAT_W'({11'd0, r_eff} * {4'd0, w_eff}) + sbmf_pkg::LAT_W'(r_eff);
   end

   // ---------------- window coordinates, clamped to the frame ----------------
   logic [RW+1:0] yv;
   logic [CW+1:0] xv;
   logic [RW-1:0] yy;
   logic [CW-1:0] xx;

   always_comb begin
      yv = {2'b00, wy_ff} + (RW+2)'(i_ff) - (RW+2)'(r_eff);
      xv = {2'b00, wx_ff} + (CW+2)'(j_ff) - (CW+2)'(r_eff);
      if (yv[RW+1]) begin
         yy = '0;
      end else if (yv > {1'b0, hm1}) begin
         yy = hm1[RW-1:0];
      end else begin
         yy = yv[RW-1:0];
      end
      if (xv[CW+1]) begin
         xx = '0;
      end else if (xv > {1'b0, wm1}) begin
         xx = wm1[CW-1:0];
      end else begin
         xx = xv[CW-1:0];
      end
   end

   // ---------------- next-state logic ----------------
   logic           acc_req;
   logic           wrap_px, emit;
   logic [NW-1:0]  b_in_cnt, b_out_cnt;
   logic [CW-1:0]  b_in_x, b_out_x;
   logic [RW-1:0]  b_in_y, b_out_y;
   logic [sbmf_pkg::WIN_W-1:0] win_end;

   // a CSR write takes the idle cycle, so no transaction is taken beside it
   assign req_port.ready = (state_ff == ST_IDLE) && !csr_wr_en;
   assign acc_req = req_port.valid && req_port.ready;
   assign win_end = {r_eff, 1'b0};

   always_comb begin
      state_in      = state_ff;
      radius_in     = radius_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      chan_in       = chan_ff;
      in_cnt_in     = in_cnt_ff;
      out_cnt_in    = out_cnt_ff;
      in_x_in       = in_x_ff;
      in_y_in       = in_y_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      wx_in         = wx_ff;
      wy_in         = wy_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      wlast_in      = wlast_ff;
      rd_vld_in     = 1'b0;
      alpha_pend_in = 1'b0;
      alpha_in      = alpha_ff;
      hs_in         = hs_ff;
      vs_in         = vs_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_c_in      = rsp_c_ff;
      rsp_alpha_in  = rsp_alpha_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;
      wr_addr       = {in_y_ff[sbmf_pkg::RING_W-1:0], in_x_ff};
      wr_data       = {req_port.in_alpha, req_port.in_chan2, req_port.in_chan1,
                       req_port.in_chan0};
      rd_addr       = {yy[sbmf_pkg::RING_W-1:0], xx};

      // frame wrap: a pixel after a complete frame starts over
      wrap_px   = (req_port.action == sbmf_pkg::ACT_PIXEL) && (in_cnt_ff >= total);
      b_in_cnt  = wrap_px ? '0 : in_cnt_ff;
      b_in_x    = wrap_px ? '0 : in_x_ff;
      b_in_y    = wrap_px ? '0 : in_y_ff;
      b_out_cnt = wrap_px ? '0 : out_cnt_ff;
      b_out_x   = wrap_px ? '0 : out_x_ff;
      b_out_y   = wrap_px ? '0 : out_y_ff;
      if (req_port.action == sbmf_pkg::ACT_PIXEL) begin
         emit = ((b_in_cnt + 1'b1) > NW'(lat)) && (b_out_cnt < total);
      end else begin
         emit = (in_cnt_ff == total) && (out_cnt_ff < total);
      end

      for (int c = 0; c < sbmf_pkg::NLANES; c++) begin
         mul_a[c] = '0;
      end

      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (alpha_pend_ff) begin
         alpha_in = rd_data_ff[3*PW +: PW];
      end
      if (rd_vld_ff) begin
         for (int c = 0; c < sbmf_pkg::NLANES; c++) begin
            hs_in[c] = hs_ff[c] + SW'(rd_data_ff[c*PW +: PW]);
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (csr_wr_en) begin
               case (csr_index)
                  sbmf_pkg::REG_RADIUS:  radius_in = csr_wdata[sbmf_pkg::RAD_W-1:0];
                  sbmf_pkg::REG_WIDTH:   width_in  = csr_wdata[sbmf_pkg::WID_W-1:0];
                  sbmf_pkg::REG_HEIGHT:  height_in = csr_wdata[sbmf_pkg::HGT_W-1:0];
                  sbmf_pkg::REG_CHANNEL: chan_in   = csr_wdata[sbmf_pkg::CHN_W-1:0];
                  default: ;
               endcase
               in_cnt_in  = '0;
               out_cnt_in = '0;
               in_x_in    = '0;
               in_y_in    = '0;
               out_x_in   = '0;
               out_y_in   = '0;
            end else if (acc_req) begin
               if (req_port.action == sbmf_pkg::ACT_PIXEL) begin
                  mem_we    = 1'b1;
                  wr_addr   = {b_in_y[sbmf_pkg::RING_W-1:0], b_in_x};
                  in_cnt_in = b_in_cnt + 1'b1;
                  if (b_in_x == wm1[CW-1:0]) begin
                     in_x_in = '0;
                     in_y_in = b_in_y + 1'b1;
                  end else begin
                     in_x_in = b_in_x + 1'b1;
                     in_y_in = b_in_y;
                  end
                  out_cnt_in = b_out_cnt;
                  out_x_in   = b_out_x;
                  out_y_in   = b_out_y;
               end
               if (emit) begin
                  wx_in      = b_out_x;
                  wy_in      = b_out_y;
                  wlast_in   = (b_out_cnt == total - 1'b1);
                  out_cnt_in = b_out_cnt + 1'b1;
                  if (b_out_x == wm1[CW-1:0]) begin
                     out_x_in = '0;
                     out_y_in = b_out_y + 1'b1;
                  end else begin
                     out_x_in = b_out_x + 1'b1;
                     out_y_in = b_out_y;
                  end
                  state_in = ST_ALPHA;
               end
            end
         end
         ST_ALPHA: begin
            rd_addr       = {wy_ff[sbmf_pkg::RING_W-1:0], wx_ff};
            alpha_pend_in = 1'b1;
            i_in          = '0;
            j_in          = '0;
            for (int c = 0; c < sbmf_pkg::NLANES; c++) begin
               hs_in[c] = '0;
               vs_in[c] = '0;
            end
            state_in = ST_ROW;
         end
         ST_ROW: begin
            rd_vld_in = 1'b1;
            if (j_ff == win_end) begin
               j_in     = '0;
               state_in = ST_HWAIT;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_HWAIT: begin
            state_in = ST_HDIV;
         end
         ST_HDIV: begin
            for (int c = 0; c < sbmf_pkg::NLANES; c++) begin
               mul_a[c]   = hs_ff[c] + SW'(r_eff);
               prod_in[c] = {{sbmf_pkg::RECIP_W{1'b0}}, mul_a[c]} * {{SW{1'b0}}, recip};
            end
            state_in = ST_HACC;
         end
         ST_HACC: begin
            for (int c = 0; c < sbmf_pkg::NLANES; c++) begin
               vs_in[c] = vs_ff[c] + SW'(prod_ff[c][sbmf_pkg::RECIP_SHIFT +: PW]);
               hs_in[c] = '0;
            end
            if (i_ff == win_end) begin
               state_in = ST_VDIV;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_ROW;
            end
         end
         ST_VDIV: begin
            for (int c = 0; c < sbmf_pkg::NLANES; c++) begin
               mul_a[c]   = vs_ff[c] + SW'(r_eff);
               prod_in[c] = {{sbmf_pkg::RECIP_W{1'b0}}, mul_a[c]} * {{SW{1'b0}}, recip};
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               for (int c = 0; c < sbmf_pkg::NLANES; c++) begin
                  // unused colour channels read as zero
                  rsp_c_in[c] = (sbmf_pkg::CHN_W'(c) < ch_eff) ?
                                prod_ff[c][sbmf_pkg::RECIP_SHIFT +: PW] : '0;
               end
               rsp_alpha_in = (ch_eff == sbmf_pkg::CHAN_ALPHA) ? alpha_ff : '0;
               rsp_last_in  = wlast_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------- ring memory ----------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pix_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= pix_mem[rd_addr];
   end

   // ---------------- state and registered outputs ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         radius_ff     <= sbmf_pkg::RADIUS_RST;
         width_ff      <= sbmf_pkg::WIDTH_RST;
         height_ff     <= sbmf_pkg::HEIGHT_RST;
         chan_ff       <= sbmf_pkg::CHANNEL_RST;
         in_cnt_ff     <= '0;
         out_cnt_ff    <= '0;
         in_x_ff       <= '0;
         in_y_ff       <= '0;
         out_x_ff      <= '0;
         out_y_ff      <= '0;
         rd_vld_ff     <= 1'b0;
         alpha_pend_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         radius_ff     <= radius_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         chan_ff       <= chan_in;
         in_cnt_ff     <= in_cnt_in;
         out_cnt_ff    <= out_cnt_in;
         in_x_ff       <= in_x_in;
         in_y_ff       <= in_y_in;
         out_x_ff      <= out_x_in;
         out_y_ff      <= out_y_in;
         rd_vld_ff     <= rd_vld_in;
         alpha_pend_ff <= alpha_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      wx_ff        <= wx_in;
      wy_ff        <= wy_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      wlast_ff     <= wlast_in;
      alpha_ff     <= alpha_in;
      hs_ff        <= hs_in;
      vs_ff        <= vs_in;
      prod_ff      <= prod_in;
      rsp_c_ff     <= rsp_c_in;
      rsp_alpha_ff <= rsp_alpha_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.out_chan0  = rsp_c_ff[0];
   assign rsp_port.out_chan1  = rsp_c_ff[1];
   assign rsp_port.out_chan2  = rsp_c_ff[2];
   assign rsp_port.out_alpha  = rsp_alpha_ff;
   assign rsp_port.frame_last = rsp_last_ff;

   // ---------------- assertions ----------------
   // results never run ahead of arrived pixels
   a_out_behind_in: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= in_cnt_ff)
      else $error("result count passed pixel count");

   // pixel count never passes the frame size
   a_in_in_frame: assert property (@(posedge clock) disable iff (reset)
      in_cnt_ff <= total)
      else $error("pixel count beyond frame");

   // clamped radius is nonzero and keeps the window inside the frame
   a_radius_ok: assert property (@(posedge clock) disable iff (reset)
      (r_eff != 4'd0) && (11'(r_eff) <= wm1) && (13'(r_eff) <= hm1))
      else $error("effective radius out of range");

endmodule
